// ===== design/tlf_pkg.sv =====
// Shared types, character codes and helpers of the text line folder.
package tlf_pkg;

    localparam logic [7:0] CH_HYPHEN  = 8'd45;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT,
        ST_HYPH,
        ST_NL,
        ST_HFIX,
        ST_COPY,
        ST_PUT
    } t_state;

    // what happens to the line buffer once the emitted line is done
    typedef enum logic [1:0] {
        OP_NONE,
        OP_RESTART,
        OP_HYPH,
        OP_MOVE
    } t_op;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
    } t_beat;

    function automatic logic is_blank(input logic [7:0] ch);
        return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NEWLINE);
    endfunction

endpackage

// ===== design/tlf_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module tlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // read data holds while no read is issued
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/tlf_out_reg.sv =====
// Output register of the folder: holds one result beat toward the consumer.
module tlf_out_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tlf_pkg::t_beat i_beat,
    output logic          o_push_ok,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [7:0]    o_out_char,
    output logic          o_last_of_run
);

    logic           r_vld;
    tlf_pkg::t_beat r_beat;
    logic           load_ok;

    assign load_ok = !r_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load_ok) begin
            r_vld <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_ok && i_push) begin
            r_beat <= i_beat;
        end
    end

    assign o_push_ok     = load_ok;
    assign o_out_valid   = r_vld;
    assign o_out_char    = r_beat.out_char;
    assign o_last_of_run = r_beat.last_of_run;

endmodule

// ===== design/tlf_seq.sv =====
// Folder sequencer: decodes each character, drives the line buffer RAM, emits beats.
module tlf_seq #(
    parameter int LINE_WIDTH = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic [7:0]     i_in_char,
    input  logic           i_end_of_input,
    output logic           o_push,
    output tlf_pkg::t_beat o_beat,
    input  logic           i_push_ok
);

    localparam int AW = $clog2(LINE_WIDTH);
    localparam int FW = $clog2(LINE_WIDTH + 1);

    tlf_pkg::t_state r_state, n_state;
    tlf_pkg::t_op    r_op, n_op;
    logic            r_hyph, n_hyph;
    logic [FW-1:0]   r_fill, n_fill;
    logic            r_ts, n_ts;
    logic            r_np, n_np;
    logic            r_fw, n_fw;
    logic            r_bvld, n_bvld;
    logic [AW-1:0]   r_bpos, n_bpos;
    logic [7:0]      r_ch, n_ch;
    logic [AW-1:0]   r_ridx, n_ridx;
    logic [AW-1:0]   r_widx, n_widx;
    logic [FW-1:0]   r_left, n_left;

    logic            acc;
    logic            d_emit;
    logic [FW-1:0]   d_len;
    logic            d_hyph;
    tlf_pkg::t_op    d_op;
    logic            d_we;
    logic [AW-1:0]   d_waddr;

    logic            blank, nl, full;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;

    assign acc        = i_in_valid && (r_state == tlf_pkg::ST_IDLE);
    assign o_in_stall = (r_state != tlf_pkg::ST_IDLE);

    assign blank = tlf_pkg::is_blank(i_in_char);
    assign nl    = (i_in_char == tlf_pkg::CH_NEWLINE);
    assign full  = (r_fill >= FW'(LINE_WIDTH));

    // item decode; r_bpos tracks the last blank written into the current line
    always_comb begin
        d_emit  = 1'b0;
        d_len   = '0;
        d_hyph  = 1'b0;
        d_op    = tlf_pkg::OP_NONE;
        d_we    = 1'b0;
        d_waddr = '0;
        n_fill  = r_fill;
        n_ts    = r_ts;
        n_np    = r_np;
        n_fw    = r_fw;
        n_bvld  = r_bvld;
        n_bpos  = r_bpos;
        if (acc) begin
            priority if (i_end_of_input) begin
                d_emit = 1'b1;
                d_len  = r_fill;
                n_fill = '0;
                n_ts   = 1'b0;
                n_np   = 1'b0;
                n_fw   = 1'b0;
                n_bvld = 1'b0;
            end else if (!r_ts) begin
                priority if (nl && r_np) begin
                    d_emit = 1'b1;
                end else if (nl) begin
                    n_np = 1'b1;
                end else if (!blank) begin
                    d_we   = 1'b1;
                    n_fill = FW'(1);
                    n_ts   = 1'b1;
                    n_fw   = 1'b1;
                    n_np   = 1'b0;
                    n_bvld = 1'b0;
                end else begin
                    // leading space or tab: dropped
                end
            end else if (nl && !r_np) begin
                d_emit = 1'b1;
                d_len  = r_fill;
                n_fill = '0;
                n_ts   = 1'b0;
                n_fw   = 1'b0;
                n_np   = 1'b1;
                n_bvld = 1'b0;
            end else if (full) begin
                d_emit = 1'b1;
                n_bvld = 1'b0;
                priority if (blank) begin
                    d_len  = FW'(LINE_WIDTH);
                    n_fill = '0;
                    n_np   = 1'b0;
                    n_ts   = 1'b0;
                    n_fw   = 1'b0;
                end else if (r_bvld && (r_bpos == AW'(LINE_WIDTH - 1))) begin
                    // line ends on a blank: new character opens the next line
                    d_len  = FW'(LINE_WIDTH);
                    d_op   = tlf_pkg::OP_RESTART;
                    n_fill = FW'(1);
                    n_fw   = 1'b1;
                end else if (r_fw || !r_bvld) begin
                    d_len  = FW'(LINE_WIDTH - 1);
                    d_hyph = 1'b1;
                    d_op   = tlf_pkg::OP_HYPH;
                    n_fill = FW'(2);
                end else begin
                    d_len  = FW'(r_bpos) + FW'(1);
                    d_op   = tlf_pkg::OP_MOVE;
                    n_fill = FW'(LINE_WIDTH) - FW'(r_bpos);
                    n_fw   = 1'b1;
                end
            end else begin
                if (blank) begin
                    n_fw   = 1'b0;
                    n_bvld = 1'b1;
                    n_bpos = r_fill[AW-1:0];
                end
                d_we    = 1'b1;
                d_waddr = r_fill[AW-1:0];
                n_fill  = r_fill + FW'(1);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tlf_pkg::ST_IDLE: begin
                if (acc && d_emit) begin
                    if (d_len != '0) begin
                        n_state = tlf_pkg::ST_EMIT;
                    end else begin
                        n_state = d_hyph ? tlf_pkg::ST_HYPH : tlf_pkg::ST_NL;
                    end
                end
            end
            tlf_pkg::ST_EMIT: begin
                if (i_push_ok && (r_left == FW'(1))) begin
                    n_state = r_hyph ? tlf_pkg::ST_HYPH : tlf_pkg::ST_NL;
                end
            end
            tlf_pkg::ST_HYPH: begin
                if (i_push_ok) begin
                    n_state = tlf_pkg::ST_NL;
                end
            end
            tlf_pkg::ST_NL: begin
                if (i_push_ok) begin
                    unique case (r_op)
                        tlf_pkg::OP_HYPH: n_state = tlf_pkg::ST_HFIX;
                        tlf_pkg::OP_MOVE: n_state = tlf_pkg::ST_COPY;
                        default:          n_state = tlf_pkg::ST_IDLE;
                    endcase
                end
            end
            tlf_pkg::ST_HFIX: n_state = tlf_pkg::ST_IDLE;
            tlf_pkg::ST_COPY: begin
                if (r_left == FW'(1)) begin
                    n_state = tlf_pkg::ST_PUT;
                end
            end
            tlf_pkg::ST_PUT:  n_state = tlf_pkg::ST_IDLE;
            default:          n_state = tlf_pkg::ST_IDLE;
        endcase
    end

    // RAM accesses and result beats
    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = r_ch;
        ram_re      = 1'b0;
        ram_raddr   = r_ridx;
        o_push      = 1'b0;
        o_beat      = '{out_char: tlf_pkg::CH_NEWLINE, last_of_run: 1'b1};
        unique case (r_state)
            tlf_pkg::ST_IDLE: begin
                ram_we    = d_we;
                ram_waddr = d_waddr;
                ram_wdata = i_in_char;
                if (acc && d_emit && (d_len != '0)) begin
                    ram_re    = 1'b1;
                    ram_raddr = '0;
                end
            end
            tlf_pkg::ST_EMIT: begin
                o_push = 1'b1;
                o_beat = '{out_char: ram_rdata, last_of_run: 1'b0};
                if (i_push_ok && (r_left != FW'(1))) begin
                    ram_re = 1'b1;
                end
            end
            tlf_pkg::ST_HYPH: begin
                o_push    = 1'b1;
                o_beat    = '{out_char: tlf_pkg::CH_HYPHEN, last_of_run: 1'b0};
                // fetch the character carried to the next line
                ram_re    = 1'b1;
                ram_raddr = AW'(LINE_WIDTH - 1);
            end
            tlf_pkg::ST_NL: begin
                o_push = 1'b1;
                if (i_push_ok) begin
                    unique case (r_op)
                        tlf_pkg::OP_RESTART: begin
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                        end
                        tlf_pkg::OP_HYPH: begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(1);
                        end
                        tlf_pkg::OP_MOVE: begin
                            ram_re    = 1'b1;
                            ram_raddr = r_bpos + AW'(1);
                        end
                        default: ;
                    endcase
                end
            end
            tlf_pkg::ST_HFIX: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = ram_rdata;
            end
            tlf_pkg::ST_COPY: begin
                ram_we    = 1'b1;
                ram_waddr = r_widx;
                ram_wdata = ram_rdata;
                if (r_left != FW'(1)) begin
                    ram_re = 1'b1;
                end
            end
            tlf_pkg::ST_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_widx;
            end
            default: ;
        endcase
    end

    // sequencing counters
    always_comb begin
        n_op   = r_op;
        n_hyph = r_hyph;
        n_ch   = r_ch;
        n_ridx = r_ridx;
        n_widx = r_widx;
        n_left = r_left;
        unique case (r_state)
            tlf_pkg::ST_IDLE: begin
                if (acc) begin
                    n_ch   = i_in_char;
                    n_op   = d_op;
                    n_hyph = d_hyph;
                    n_left = d_len;
                    n_ridx = AW'(1);
                end
            end
            tlf_pkg::ST_EMIT: begin
                if (i_push_ok) begin
                    n_left = r_left - FW'(1);
                    n_ridx = r_ridx + AW'(1);
                end
            end
            tlf_pkg::ST_NL: begin
                if (i_push_ok && (r_op == tlf_pkg::OP_MOVE)) begin
                    n_ridx = r_bpos + AW'(2);
                    n_widx = '0;
                    n_left = FW'(LINE_WIDTH - 1) - FW'(r_bpos);
                end
            end
            tlf_pkg::ST_COPY: begin
                n_left = r_left - FW'(1);
                n_ridx = r_ridx + AW'(1);
                n_widx = r_widx + AW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlf_pkg::ST_IDLE;
            r_op    <= tlf_pkg::OP_NONE;
            r_left  <= '0;
            r_fill  <= '0;
            r_ts    <= 1'b0;
            r_np    <= 1'b0;
            r_fw    <= 1'b0;
            r_bvld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_left  <= n_left;
            r_fill  <= n_fill;
            r_ts    <= n_ts;
            r_np    <= n_np;
            r_fw    <= n_fw;
            r_bvld  <= n_bvld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hyph <= n_hyph;
        r_ch   <= n_ch;
        r_ridx <= n_ridx;
        r_widx <= n_widx;
        r_bpos <= n_bpos;
    end

    tlf_ram #(
        .WIDTH (8),
        .DEPTH (LINE_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

endmodule

// ===== design/text_line_folder_unit.sv =====
// Top level of the text line folder: sequencer with line buffer RAM and output register.
// A character that is only stored or dropped leaves the sequencer idle; one that ends a line
// sends that line from the RAM read port, one beat per cycle while the output does not stall,
// through the RAM read register and the output register, then the newline; a hyphenation
// adds a hyphen beat and a carry write, a word move a RAM copy sweep and one more write.
// Synchronous active-low reset clears the flags and fill count; the buffer is not cleared.
module text_line_folder_unit #(
    parameter int LINE_WIDTH = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_char,
    input  logic       i_end_of_input,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_char,
    output logic       o_last_of_run
);

    logic           push;
    logic           push_ok;
    tlf_pkg::t_beat beat;

    tlf_seq #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_char      (i_in_char),
        .i_end_of_input (i_end_of_input),
        .o_push         (push),
        .o_beat         (beat),
        .i_push_ok      (push_ok)
    );

    tlf_out_reg u_out_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_beat        (beat),
        .o_push_ok     (push_ok),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_char    (o_out_char),
        .o_last_of_run (o_last_of_run)
    );

    // end of text always flushes at least a newline
    a_eoi_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_end_of_input |=> o_in_stall)
        else $error("end of input did not start a flush");

    // the newline closes every run and nothing else carries it
    a_last_is_nl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_of_run == (o_out_char == tlf_pkg::CH_NEWLINE)))
        else $error("last beat flag and newline disagree");

    // the input side goes busy only right after taking a beat
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && !o_in_stall))
        else $error("input stalled without an accepted beat");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of the text line folder: character stream in, folded lines out.
module testbench;

    localparam int LINE_W      = 10;
    localparam int FILL_W      = $clog2(LINE_W + 1);
    localparam int TARGET_CHARS = 370;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLDOFF_LEN = 150;
    localparam int HOLDOFF_AT  = 80;
    localparam int DRAIN_CYCLES = 2 * LINE_W + 10;

    localparam int STALL_NONE  = 0;
    localparam int STALL_LIGHT = 1;
    localparam int STALL_HEAVY = 2;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
    } t_item;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] in_char = 8'd0;
    logic       in_eoi = 1'b0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] out_char;
    logic       out_last;

    text_line_folder_unit #(
        .LINE_WIDTH(LINE_W)
    ) u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_in_char      (in_char),
        .i_end_of_input (in_eoi),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_out_char     (out_char),
        .o_last_of_run  (out_last)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------- folding predictor
    logic [7:0]        line_buf [LINE_W];
    logic [FILL_W-1:0] line_fill = '0;
    logic              text_open = 1'b0;
    logic              nl_seen = 1'b0;
    logic              in_first_word = 1'b0;
    int                beats_now;
    tlf_pkg::t_beat    expected_beats [$];

    function automatic logic is_ws(input logic [7:0] c);
        return c == tlf_pkg::CH_SPACE || c == tlf_pkg::CH_TAB || c == tlf_pkg::CH_NEWLINE;
    endfunction

    task automatic put_beat(input logic [7:0] c);
        tlf_pkg::t_beat b;
        b.out_char    = c;
        b.last_of_run = 1'b0;
        expected_beats.push_back(b);
        beats_now++;
    endtask

    task automatic emit_line(input int len);
        for (int k = 0; k < len; k++)
            put_beat(line_buf[k]);
        put_beat(tlf_pkg::CH_NEWLINE);
    endtask

    task automatic fold_char(input logic [7:0] ch, input logic eoi);
        tlf_pkg::t_beat b;
        logic [7:0]     carried;
        logic [7:0]     moved [LINE_W];
        int             cnt;
        int             pos;
        bit             found;
        beats_now = 0;
        if (eoi) begin
            emit_line(int'(line_fill));
            line_fill     = '0;
            text_open     = 1'b0;
            nl_seen       = 1'b0;
            in_first_word = 1'b0;
        end else if (!text_open) begin
            if (ch == tlf_pkg::CH_NEWLINE && nl_seen) begin
                put_beat(tlf_pkg::CH_NEWLINE);
            end else if (ch == tlf_pkg::CH_NEWLINE) begin
                nl_seen = 1'b1;
            end else if (!is_ws(ch)) begin
                line_buf[0]   = ch;
                line_fill     = FILL_W'(1);
                text_open     = 1'b1;
                in_first_word = 1'b1;
                nl_seen       = 1'b0;
            end
        end else if (ch == tlf_pkg::CH_NEWLINE && !nl_seen) begin
            emit_line(int'(line_fill));
            line_fill     = '0;
            text_open     = 1'b0;
            in_first_word = 1'b0;
            nl_seen       = 1'b1;
        end else if (int'(line_fill) >= LINE_W) begin
            if (is_ws(ch)) begin
                emit_line(LINE_W);
                line_fill     = '0;
                nl_seen       = 1'b0;
                text_open     = 1'b0;
                in_first_word = 1'b0;
            end else if (is_ws(line_buf[LINE_W-1])) begin
                emit_line(LINE_W);
                line_buf[0]   = ch;
                line_fill     = FILL_W'(1);
                in_first_word = 1'b1;
            end else begin
                found = 1'b0;
                pos   = LINE_W - 1;
                if (!in_first_word) begin
                    while (pos > 0 && !found) begin
                        pos--;
                        found = is_ws(line_buf[pos]);
                    end
                end
                if (!found) begin
                    // hyphenate: last held char goes to the next line, '-' takes its slot
                    carried = line_buf[LINE_W-1];
                    line_buf[LINE_W-1] = tlf_pkg::CH_HYPHEN;
                    emit_line(LINE_W);
                    line_buf[0] = carried;
                    line_buf[1] = ch;
                    line_fill   = FILL_W'(2);
                end else begin
                    cnt = 0;
                    for (int k = pos + 1; k < LINE_W; k++) begin
                        moved[cnt] = line_buf[k];
                        cnt++;
                    end
                    moved[cnt] = ch;
                    cnt++;
                    emit_line(pos + 1);
                    for (int k = 0; k < cnt; k++)
                        line_buf[k] = moved[k];
                    line_fill     = FILL_W'(cnt);
                    in_first_word = 1'b1;
                end
            end
        end else begin
            if (is_ws(ch))
                in_first_word = 1'b0;
            line_buf[line_fill] = ch;
            line_fill = line_fill + 1'b1;
        end
        if (beats_now > 0) begin
            b = expected_beats.pop_back();
            b.last_of_run = 1'b1;
            expected_beats.push_back(b);
        end
    endtask

    // ---------------------------------------------------------------- stimulus
    t_item text_q [$];
    int    counted_chars = 0;

    task automatic push_item(input logic [7:0] c, input logic eoi);
        t_item it;
        it.ch  = c;
        it.eoi = eoi;
        text_q.push_back(it);
        counted_chars++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_item(8'(s[i]), 1'b0);
    endtask

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(97, 122));
        c = 8'($urandom_range(1, 255));
        while (is_ws(c))
            c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    task automatic push_word(input int len);
        for (int i = 0; i < len; i++)
            push_item(word_char(), 1'b0);
    endtask

    task automatic build_text();
        int unsigned roll;
        int unsigned sep;
        // double newline, leading blanks, then an 11-char first word that must hyphenate
        push_text("\n\n \t");
        push_item(8'hFF, 1'b0);
        push_item(8'h01, 1'b0);
        push_text("cdefghijk");
        // fill the line so it ends on a blank, then a char that opens a new line
        push_text(" mnopqr s");
        push_item(8'h00, 1'b1);

        while (counted_chars < TARGET_CHARS) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                push_item(8'($urandom_range(1, 255)), 1'b1);
            end else if (roll < 10) begin
                push_item(8'($urandom_range(1, 255)), 1'b0);
            end else begin
                if ($urandom_range(0, 4) == 0)
                    push_word($urandom_range(9, 14));
                else
                    push_word($urandom_range(1, 8));
                sep = $urandom_range(0, 99);
                if (sep < 70) begin
                    push_item($urandom_range(0, 1) ? tlf_pkg::CH_SPACE : tlf_pkg::CH_TAB, 1'b0);
                end else if (sep < 82) begin
                    repeat ($urandom_range(2, 3))
                        push_item($urandom_range(0, 1) ? tlf_pkg::CH_SPACE : tlf_pkg::CH_TAB,
                                  1'b0);
                end else if (sep < 96) begin
                    repeat ($urandom_range(1, 3))
                        push_item(tlf_pkg::CH_NEWLINE, 1'b0);
                end else begin
                    push_item(8'($urandom_range(1, 255)), 1'b1);
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- character driver
    t_item drive_item;
    int    burst_left = 0;
    int    gap_left = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                fold_char(in_char, in_eoi);
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (text_q.size() > 0) begin
                    drive_item = text_q.pop_front();
                    in_char  <= drive_item.ch;
                    in_eoi   <= drive_item.eoi;
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- output stall pattern
    int beats_seen = 0;
    int holdoff_left = 0;
    bit holdoff_done = 1'b0;
    int stall_mode = STALL_NONE;
    int mode_left = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall)
                beats_seen++;
            // one long hold-off so the folder backs up into its input
            if (!holdoff_done && beats_seen >= HOLDOFF_AT) begin
                holdoff_left = HOLDOFF_LEN;
                holdoff_done = 1'b1;
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
                mode_left  = $urandom_range(16, 96);
            end else begin
                mode_left--;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                out_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    default:     out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- output monitor
    int             mismatches = 0;
    tlf_pkg::t_beat want;

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_beats.size() == 0) begin
                $error("unexpected beat: out_char %0d last_of_run %0b", out_char, out_last);
                mismatches++;
            end else begin
                want = expected_beats.pop_front();
                if (out_char !== want.out_char) begin
                    $error("out_char: expected %0d, got %0d", want.out_char, out_char);
                    mismatches++;
                end
                if (out_last !== want.last_of_run) begin
                    $error("last_of_run: expected %0b, got %0b", want.last_of_run, out_last);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- sequence and end of run
    initial begin
        build_text();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (!(text_q.size() == 0 && !in_valid && expected_beats.size() == 0))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_beats.size() != 0)
            $error("%0d expected beats never arrived", expected_beats.size());
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/tlf_pkg.sv
design/tlf_ram.sv
design/tlf_out_reg.sv
design/tlf_seq.sv
design/text_line_folder_unit.sv
tb/testbench.sv
